### sv/lpe_pkg.sv
// shared types and constants for the line program entry encoder
package lpe_pkg;

    // default number of address bytes in set_address
    localparam int DEFAULT_ADDRESS_BYTES = 8;

    // line program opcodes and fixed bytes
    localparam logic [7:0] OP_EXTENDED    = 8'h00;
    localparam logic [7:0] OP_COPY        = 8'h01;
    localparam logic [7:0] OP_ADVANCE_LN  = 8'h03;
    localparam logic [7:0] OP_SET_FILE    = 8'h04;
    localparam logic [7:0] EXT_END_SEQ    = 8'h01;
    localparam logic [7:0] EXT_SET_ADDR   = 8'h02;

    // leb128 fields
    localparam logic [6:0] LEB_DATA_MASK  = 7'h7F;
    localparam logic [7:0] LEB_MORE       = 8'h80;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_END0,
        ST_END1,
        ST_END2,
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_ADDR,
        ST_FILEOP,
        ST_ULEB,
        ST_LINEOP,
        ST_SLEB,
        ST_COPY
    } t_state;

endpackage

### sv/line_program_entry_encoder_top.sv
// line program entry encoder: one line-table row in, its line program bytes out
// an accepted row passes the sequencer state register, then the output register
// throughput: one byte per cycle from a single shift unit unless stalled; a row is
//   ADDRESS_BYTES + 6 + uleb bytes + sleb bytes (up to 24 at 8 bytes),
//   end_sequence is 3 bytes; the next transaction is accepted only back in idle
// reset: synchronous active low, clears the sequencer and output valid
module line_program_entry_encoder_top
    import lpe_pkg::*;
#(
    parameter int ADDRESS_BYTES = DEFAULT_ADDRESS_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [63:0]        i_address,
    input  logic [31:0]        i_file_num,
    input  logic signed [31:0] i_line_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    // address size bounded to 1..8 bytes
    localparam int ABYTES = (ADDRESS_BYTES > 8) ? 8 :
                            ((ADDRESS_BYTES < 1) ? 1 : ADDRESS_BYTES);
    // work register also carries the 32-bit leb128 operands
    localparam int WORK_W = ((ABYTES > 4) ? ABYTES : 4) * 8;
    localparam int CNT_W  = (ABYTES > 1) ? $clog2(ABYTES) : 1;

    t_state              r_state, n_state;
    logic [WORK_W-1:0]   r_work, n_work;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [31:0]         r_held_file;
    logic [31:0]         r_held_line;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_last;

    logic                w_adv;
    logic                w_accept;
    logic                n_emit;
    logic [7:0]          n_out_byte;
    logic                n_last;
    logic [WORK_W-1:0]   w_shifted;
    logic                w_sh8;
    logic                w_arith;
    logic                w_uleb_done;
    logic                w_sleb_done;

    // handshake
    assign w_adv    = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && (r_state == ST_IDLE);

    // shared shift unit: bytes for the address, 7-bit groups for leb128
    assign w_sh8   = (r_state == ST_ADDR);
    assign w_arith = (r_state == ST_SLEB);
    always_comb begin
        if (w_sh8) begin
            w_shifted = r_work >> 8;
        end else if (w_arith) begin
            w_shifted = WORK_W'($signed(r_work) >>> 7);
        end else begin
            w_shifted = r_work >> 7;
        end
    end

    // leb128 termination tests on the shifted value
    assign w_uleb_done = (w_shifted[31:0] == 32'd0);
    assign w_sleb_done = ((w_shifted[31:0] == 32'd0) && !r_work[6]) ||
                         ((w_shifted[31:0] == 32'hFFFF_FFFF) && r_work[6]);

    // sequencer: next state and emitted byte
    always_comb begin
        n_state    = r_state;
        n_work     = r_work;
        n_count    = r_count;
        n_emit     = 1'b0;
        n_out_byte = OP_EXTENDED;
        n_last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_action ? ST_END0 : ST_HDR0;
                    n_work  = WORK_W'(i_address);
                    n_count = '0;
                end
            end
            ST_END0: begin
                n_emit     = 1'b1;
                n_out_byte = OP_EXTENDED;
                n_state    = ST_END1;
            end
            ST_END1: begin
                n_emit     = 1'b1;
                n_out_byte = 8'd1;
                n_state    = ST_END2;
            end
            ST_END2: begin
                n_emit     = 1'b1;
                n_out_byte = EXT_END_SEQ;
                n_last     = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_HDR0: begin
                n_emit     = 1'b1;
                n_out_byte = OP_EXTENDED;
                n_state    = ST_HDR1;
            end
            ST_HDR1: begin
                n_emit     = 1'b1;
                n_out_byte = 8'(ABYTES + 1);
                n_state    = ST_HDR2;
            end
            ST_HDR2: begin
                n_emit     = 1'b1;
                n_out_byte = EXT_SET_ADDR;
                n_state    = ST_ADDR;
            end
            ST_ADDR: begin
                n_emit     = 1'b1;
                n_out_byte = r_work[7:0];
                n_work     = w_shifted;
                n_count    = r_count + 1'b1;
                if (r_count == CNT_W'(ABYTES - 1)) begin
                    n_state = ST_FILEOP;
                end
            end
            ST_FILEOP: begin
                n_emit     = 1'b1;
                n_out_byte = OP_SET_FILE;
                n_work     = WORK_W'(r_held_file);
                n_state    = ST_ULEB;
            end
            ST_ULEB: begin
                n_emit     = 1'b1;
                n_out_byte = {1'b0, r_work[6:0] & LEB_DATA_MASK} |
                             (w_uleb_done ? 8'd0 : LEB_MORE);
                n_work     = w_shifted;
                if (w_uleb_done) begin
                    n_state = ST_LINEOP;
                end
            end
            ST_LINEOP: begin
                n_emit     = 1'b1;
                n_out_byte = OP_ADVANCE_LN;
                n_work     = WORK_W'($signed(r_held_line));
                n_state    = ST_SLEB;
            end
            ST_SLEB: begin
                n_emit     = 1'b1;
                n_out_byte = {1'b0, r_work[6:0] & LEB_DATA_MASK} |
                             (w_sleb_done ? 8'd0 : LEB_MORE);
                n_work     = w_shifted;
                if (w_sleb_done) begin
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                n_emit     = 1'b1;
                n_out_byte = OP_COPY;
                n_last     = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer registers; non-idle states only move when a byte can go out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else if (w_accept || (w_adv && r_state != ST_IDLE)) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // work register and held row
    always_ff @(posedge i_clk) begin
        if (w_accept || (w_adv && r_state != ST_IDLE)) begin
            r_work <= n_work;
        end
        if (w_accept && !i_action) begin
            r_held_file <= i_file_num;
            r_held_line <= i_line_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_emit) begin
            r_out_byte <= n_out_byte;
            r_last     <= n_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_last;

    // address byte counter stays inside the address field
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADDR) |-> (r_count <= CNT_W'(ABYTES - 1)))
        else $error("address byte counter out of range");

    // an end transaction starts the end_sequence run
    a_end_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action) |=> (r_state == ST_END0))
        else $error("end transaction did not start end_sequence");

    // a row transaction starts with the extended opcode header
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_action) |=> (r_state == ST_HDR0))
        else $error("row transaction did not start set_address");

    // a byte leaving the sleb stage reaches the output register
    a_sleb_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SLEB && w_adv) |=> (o_valid && !o_last))
        else $error("sleb byte not presented");

endmodule

### tb/line_program_entry_encoder_top_tb.sv
// testbench for the line program entry encoder: directed and random rows against a byte predictor
module line_program_entry_encoder_top_tb;
    import lpe_pkg::*;

    // action codes of an input transaction
    localparam logic ACT_ROW = 1'b0;
    localparam logic ACT_END = 1'b1;

    // address bytes written by set_address, bounded as the block bounds them
    localparam int ABYTES = (DEFAULT_ADDRESS_BYTES > 8) ? 8 :
                            ((DEFAULT_ADDRESS_BYTES < 1) ? 1 : DEFAULT_ADDRESS_BYTES);

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 340;
    localparam int CALM_FIRST    = 150;
    localparam int CALM_LAST     = 230;
    localparam int DRAIN_IDX     = 120;
    localparam int TAIL_CYCLES   = 40;
    localparam int WATCHDOG_MAX  = 3000;

    typedef struct {
        logic        action;
        logic [63:0] address;
        logic [31:0] file_num;
        logic [31:0] line_value;
    } t_row;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } t_prog_byte;

    // byte stream predictor and checker
    class line_prog_scoreboard;
        t_prog_byte  prog_q[$];
        logic [63:0] held_address;
        logic [31:0] held_file;
        logic [31:0] held_line;
        int          errors;

        function new();
            held_address = '0;
            held_file    = '0;
            held_line    = '0;
            errors       = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            t_prog_byte e;
            e.out_byte = b;
            e.last     = 1'b0;
            prog_q.insert(prog_q.size(), e);
        endfunction

        function void push_uleb(logic [31:0] value);
            logic [31:0] v;
            logic [7:0]  b;
            logic        more;
            v    = value;
            more = 1'b1;
            while (more) begin
                b = {1'b0, v[6:0] & LEB_DATA_MASK};
                v = v >> 7;
                if (v != 0) b = b | LEB_MORE;
                else more = 1'b0;
                push_byte(b);
            end
        endfunction

        function void push_sleb(logic [31:0] value);
            logic signed [31:0] v;
            logic [7:0]         b;
            logic               more;
            v    = value;
            more = 1'b1;
            while (more) begin
                b = {1'b0, v[6:0] & LEB_DATA_MASK};
                v = v >>> 7;
                if ((v == 0 && !b[6]) || (v == -1 && b[6])) more = 1'b0;
                else b = b | LEB_MORE;
                push_byte(b);
            end
        endfunction

        // expected bytes of one accepted input transaction
        function void note_row(t_row r);
            t_prog_byte e;
            if (r.action == ACT_END) begin
                push_byte(OP_EXTENDED);
                push_byte(8'h01);
                push_byte(EXT_END_SEQ);
            end else begin
                held_address = r.address;
                held_file    = r.file_num;
                held_line    = r.line_value;
                push_byte(OP_EXTENDED);
                push_byte(8'(ABYTES + 1));
                push_byte(EXT_SET_ADDR);
                for (int i = 0; i < ABYTES; i++) push_byte(held_address[8*i +: 8]);
                push_byte(OP_SET_FILE);
                push_uleb(held_file);
                push_byte(OP_ADVANCE_LN);
                push_sleb(held_line);
                push_byte(OP_COPY);
            end
            e = prog_q.pop_back();
            e.last = 1'b1;
            prog_q.insert(prog_q.size(), e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one output transaction against the oldest expected byte
        task check_byte(logic [7:0] b, logic last);
            t_prog_byte e;
            if (prog_q.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", b, last));
            end else begin
                e = prog_q.pop_front();
                if (b !== e.out_byte)
                    report($sformatf("out_byte %02h, expected %02h", b, e.out_byte));
                if (last !== e.last)
                    report($sformatf("last %0b, expected %0b", last, e.last));
            end
        endtask

        function int pending();
            return prog_q.size();
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic               i_action     = 1'b0;
    logic [63:0]        i_address    = '0;
    logic [31:0]        i_file_num   = '0;
    logic signed [31:0] i_line_value = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_last;

    line_prog_scoreboard sb = new();
    t_row stim_q[$];
    int   next_idx   = 0;
    int   sent_count = 0;
    bit   drain_done = 1'b0;
    int   quiet_cycles = 0;

    line_program_entry_encoder_top #(
        .ADDRESS_BYTES(DEFAULT_ADDRESS_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_address   (i_address),
        .i_file_num  (i_file_num),
        .i_line_value(i_line_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void add_row(logic act, logic [63:0] addr, logic [31:0] file_idx,
                                    logic [31:0] line_val);
        t_row r;
        r.action     = act;
        r.address    = addr;
        r.file_num   = file_idx;
        r.line_value = line_val;
        stim_q.insert(stim_q.size(), r);
    endfunction

    // unsigned value of random bit length, so every leb128 length shows up
    function automatic logic [31:0] rand_file();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // signed value of random magnitude and either sign
    function automatic logic [31:0] rand_line();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic bit calm_window();
        return (next_idx >= CALM_FIRST) && (next_idx < CALM_LAST);
    endfunction

    // sender: hold a transaction until accepted, then load the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sb.note_row('{i_action, i_address, i_file_num, i_line_value});
                sent_count++;
            end
            if (!i_valid || !o_stall) begin
                if (next_idx == DRAIN_IDX && !drain_done &&
                    ((i_valid && !o_stall) || sb.pending() != 0)) begin
                    i_valid <= 1'b0;
                end else if (next_idx < stim_q.size() &&
                             (calm_window() || $urandom_range(0, 99) >= 24)) begin
                    if (next_idx == DRAIN_IDX) drain_done = 1'b1;
                    i_action     <= stim_q[next_idx].action;
                    i_address    <= stim_q[next_idx].address;
                    i_file_num   <= stim_q[next_idx].file_num;
                    i_line_value <= stim_q[next_idx].line_value;
                    i_valid      <= 1'b1;
                    next_idx++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        i_stall <= !calm_window() && ($urandom_range(0, 99) < 24);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_byte(o_out_byte, o_last);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        // directed rows: field extremes, every unsigned leb128 length boundary and several signed ones
        add_row(ACT_END, '1, '1, '1);
        add_row(ACT_ROW, '0, 32'd0, 32'sd0);
        add_row(ACT_ROW, '1, 32'hFFFF_FFFF, -32'sd1);
        add_row(ACT_ROW, 64'h0123_4567_89AB_CDEF, 32'd127, 32'sd63);
        add_row(ACT_ROW, 64'hFEDC_BA98_7654_3210, 32'd128, 32'sd64);
        add_row(ACT_ROW, 64'h8000_0000_0000_0001, 32'd16383, -32'sd64);
        add_row(ACT_ROW, 64'h7FFF_FFFF_FFFF_FFFE, 32'd16384, -32'sd65);
        add_row(ACT_ROW, 64'h00FF_00FF_00FF_00FF, 32'd2097151, 32'sd8191);
        add_row(ACT_ROW, 64'hFF00_FF00_FF00_FF00, 32'd2097152, -32'sd8192);
        add_row(ACT_ROW, 64'h0000_0000_FFFF_FFFF, 32'd268435455, 32'sd8192);
        add_row(ACT_ROW, 64'hFFFF_FFFF_0000_0000, 32'd268435456, -32'sd8193);
        add_row(ACT_ROW, 64'h1, 32'd1, 32'sh7FFF_FFFF);
        add_row(ACT_ROW, 64'h2, 32'h8000_0000, 32'sh8000_0000);
        // end transactions ignore the row fields and leave the held row alone
        add_row(ACT_END, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(ACT_END, '0, 32'd0, 32'd0);
        add_row(ACT_ROW, 64'hA5A5_5A5A_A5A5_5A5A, 32'd1048575, 32'sd1048575);
        add_row(ACT_ROW, 64'h5A5A_A5A5_5A5A_A5A5, 32'd34359, -32'sd1048576);
        add_row(ACT_END, 64'h1234, 32'd77, 32'd88);
        // random part: mostly rows, sequences closed by end transactions
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15)
                add_row(ACT_END, {$urandom, $urandom}, $urandom, $urandom);
            else
                add_row(ACT_ROW, {$urandom, $urandom}, rand_file(), rand_line());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count < stim_q.size() || sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
